/* rtl/sorted_timer_queue_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted timer queue
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_UNIT_MACROS_SVH
`define SORTED_TIMER_QUEUE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define STQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sorted timer queue check failed");
`define STQ_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("sorted timer queue forbidden condition");
`else
`define STQ_ASSERT(lbl, prop)
`define STQ_ASSERT_NEVER(lbl, cond)
`endif

`endif

/* rtl/stq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Widths, operation and status codes, and the types shared by the cells.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int DEPTH  = 64;
	localparam int ID_W   = 6;
	localparam int TIME_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_ADJUST = 2'd1,
		OP_DELETE = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STS_DONE    = 3'd0,
		STS_EXPIRED = 3'd1,
		STS_FULL    = 3'd2,
		STS_ABSENT  = 3'd3,
		STS_PRESENT = 3'd4,
		STS_NONE    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOOK,
		CELL_INSERT,
		CELL_REMOVE
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DECIDE,
		ST_TICK
	} state_t;

	typedef struct packed {
		cell_cmd_t         cmd;
		logic [ID_W-1:0]   key_id;
		logic [TIME_W-1:0] key_time;
	} cell_ctrl_t;

	// What a cell shows its neighbors: its entry and its "at or before key" flag.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] expiry;
		logic              le;
	} cell_data_t;

endpackage

/* rtl/stq_if.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface stq_in_if import stq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [ID_W-1:0]   timer_id;
	logic [TIME_W-1:0] expire_time;
	logic [TIME_W-1:0] now_time;

	modport source(output valid, op, timer_id, expire_time, now_time, input ready);
	modport sink(input valid, op, timer_id, expire_time, now_time, output ready);
endinterface

interface stq_out_if import stq_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] timer_id_out;
	logic [2:0]      status;
	logic            last;

	modport source(output valid, timer_id_out, status, last, input ready);
	modport sink(input valid, timer_id_out, status, last, output ready);
endinterface

/* rtl/stq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue cell
// Holds one timer entry; compares it with the broadcast key and shifts
// toward either neighbor on insert or removal.
// ----------------------------------------------------------------------------
module stq_cell import stq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       occ,
	input  logic       remove_en,
	input  cell_data_t left,
	input  cell_data_t right,
	output cell_data_t data,
	output logic       match
);

	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] expiry_q;
	logic              le_q;
	logic              match_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			CELL_INSERT: begin
				// Entries at or before the new expiry stay; the first later one
				// takes the new timer, the rest move one place back.
				if (!le_q) begin
					if (left.le) begin
						id_q     <= ctrl.key_id;
						expiry_q <= ctrl.key_time;
					end else begin
						id_q     <= left.id;
						expiry_q <= left.expiry;
					end
				end
			end
			CELL_REMOVE: begin
				if (remove_en) begin
					id_q     <= right.id;
					expiry_q <= right.expiry;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q    <= 1'b0;
			match_q <= 1'b0;
		end else begin
			unique case (ctrl.cmd)
				CELL_LOOK: begin
					le_q    <= occ && (expiry_q <= ctrl.key_time);
					match_q <= occ && (id_q == ctrl.key_id);
				end
				CELL_INSERT: begin
					if (!le_q) begin
						le_q <= 1'b0;
					end
					match_q <= 1'b0;
				end
				CELL_REMOVE: begin
					if (remove_en) begin
						le_q <= right.le;
					end
					match_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign data  = '{id: id_q, expiry: expiry_q, le: le_q};
	assign match = match_q;

endmodule

/* rtl/sorted_timer_queue_unit.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue
// Up to DEPTH timers kept in expiry order in a row of shifting cells.
// ----------------------------------------------------------------------------
// Commands arrive on in_ch (op, timer_id, expire_time, now_time) and results
// leave on out_ch (timer_id_out, status, last); both are valid/ready channels.
// The queue is a row of DEPTH cells. A command is taken while the control is
// idle; in the next cycle every cell compares its entry with the broadcast id
// and time at once, and then, once the output register can take the result, the
// row shifts by one place toward the insertion point or over the removed entry.
// Insert and delete: the result word is written in the step in which the row
// shifts. Adjust of a present timer: a removal pass followed by an insertion
// pass before the word; adjust of an absent timer answers like a delete.
// Tick: a "nothing expired" word if the head is not due, otherwise n expired
// timers leave one word per cycle while the output can take them, as the head
// of the row is popped, the last one with last set.
// The next command is accepted in the cycle after the last word is written.
// A word waits in the output register while out_ch.ready is low; the row
// holds still until it can hand over the next word.
// Reset empties the queue (the entry count goes to zero); entry contents are
// not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_unit_macros.svh"

module sorted_timer_queue_unit import stq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	stq_in_if.sink   in_ch,
	stq_out_if.source out_ch
);

	state_t            state_q, state_d;
	op_t               op_q, op_d;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] exp_q;
	logic [TIME_W-1:0] now_q;
	logic [CNT_W-1:0]  count_q, count_d;

	logic              res_valid_q;
	logic [ID_W-1:0]   res_id_q;
	status_t           res_status_q;
	logic              res_last_q;

	logic              emit;
	logic [ID_W-1:0]   emit_id;
	status_t           emit_status;
	logic              emit_last;
	logic              can_emit;

	cell_ctrl_t        ctrl;
	logic [DEPTH-1:0]  occ_vec;
	logic [DEPTH-1:0]  match_vec;
	logic [DEPTH-1:0]  le_vec;
	logic [DEPTH-1:0]  remove_mask;
	logic [DEPTH-1:0]  tail_mask;
	cell_data_t        data_vec [DEPTH];
	logic              present;
	logic              full;
	logic              accept;

	localparam cell_data_t LEFT_EDGE  = '{id: '0, expiry: '0, le: 1'b1};
	localparam cell_data_t RIGHT_EDGE = '{id: '0, expiry: '0, le: 1'b0};

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ_vec[i] = CNT_W'(i) < count_q;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		cell_data_t left_w, right_w;
		if (g == 0) begin : g_first
			assign left_w = LEFT_EDGE;
		end else begin : g_mid_l
			assign left_w = data_vec[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_w = RIGHT_EDGE;
		end else begin : g_mid_r
			assign right_w = data_vec[g+1];
		end

		stq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.occ       (occ_vec[g]),
			.remove_en (remove_mask[g]),
			.left      (left_w),
			.right     (right_w),
			.data      (data_vec[g]),
			.match     (match_vec[g])
		);
		assign le_vec[g] = data_vec[g].le;
	end

	assign present   = |match_vec;
	assign full      = occ_vec[DEPTH-1];
	// The match is one-hot, so this marks the matching cell and all after it.
	assign tail_mask = ~(match_vec - DEPTH'(1));
	assign can_emit  = !res_valid_q || out_ch.ready;
	assign accept    = in_ch.valid && in_ch.ready;

	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		count_d       = count_q;
		ctrl.cmd      = CELL_HOLD;
		ctrl.key_id   = id_q;
		ctrl.key_time = (op_q == OP_TICK) ? now_q : exp_q;
		remove_mask   = tail_mask;
		emit          = 1'b0;
		emit_id       = id_q;
		emit_status   = STS_DONE;
		emit_last     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOK;
					op_d    = op_t'(in_ch.op);
				end
			end
			ST_LOOK: begin
				ctrl.cmd = CELL_LOOK;
				state_d  = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (can_emit) begin
					unique case (op_q)
						OP_INSERT: begin
							emit    = 1'b1;
							state_d = ST_IDLE;
							if (present) begin
								emit_status = STS_PRESENT;
							end else if (full) begin
								emit_status = STS_FULL;
							end else begin
								ctrl.cmd = CELL_INSERT;
								count_d  = count_q + CNT_W'(1);
							end
						end
						OP_ADJUST: begin
							if (!present) begin
								emit        = 1'b1;
								emit_status = STS_ABSENT;
								state_d     = ST_IDLE;
							end else begin
								// Remove now, then run an insert pass with the new expiry.
								ctrl.cmd = CELL_REMOVE;
								count_d  = count_q - CNT_W'(1);
								op_d     = OP_INSERT;
								state_d  = ST_LOOK;
							end
						end
						OP_DELETE: begin
							emit    = 1'b1;
							state_d = ST_IDLE;
							if (!present) begin
								emit_status = STS_ABSENT;
							end else begin
								ctrl.cmd = CELL_REMOVE;
								count_d  = count_q - CNT_W'(1);
							end
						end
						OP_TICK: begin
							if (le_vec[0]) begin
								state_d = ST_TICK;
							end else begin
								emit        = 1'b1;
								emit_id     = '0;
								emit_status = STS_NONE;
								state_d     = ST_IDLE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_TICK: begin
				if (can_emit) begin
					// Pop the head; the due flags shift along with the entries.
					ctrl.cmd    = CELL_REMOVE;
					remove_mask = '1;
					count_d     = count_q - CNT_W'(1);
					emit        = 1'b1;
					emit_id     = data_vec[0].id;
					emit_status = STS_EXPIRED;
					emit_last   = !le_vec[1];
					if (!le_vec[1]) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_INSERT;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			count_q <= count_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q  <= in_ch.timer_id;
			exp_q <= in_ch.expire_time;
			now_q <= in_ch.now_time;
		end
		if (emit) begin
			res_id_q     <= emit_id;
			res_status_q <= emit_status;
			res_last_q   <= emit_last;
		end
	end

	assign in_ch.ready         = (state_q == ST_IDLE);
	assign out_ch.valid        = res_valid_q;
	assign out_ch.timer_id_out = res_id_q;
	assign out_ch.status       = res_status_q;
	assign out_ch.last         = res_last_q;

	// Ids in the queue are unique, so at most one cell can match.
	`STQ_ASSERT_NEVER(a_match_unique, !$onehot0(match_vec))
	// While idle the entry count does not move.
	`STQ_ASSERT(a_idle_count, (state_q == ST_IDLE) |=> (count_q == $past(count_q)))
	// The pop loop only runs while the head entry is due.
	`STQ_ASSERT(a_tick_head_due, (state_q == ST_TICK) |-> le_vec[0])
	// The count never exceeds the number of cells.
	`STQ_ASSERT_NEVER(a_count_range, count_q > CNT_W'(DEPTH))

endmodule
